// ===== sv/sisp_pkg.sv =====
// Package for the serial input scanner and pulse classifier.
// Holds sizes, the scan stage and register codes, shared structs and helpers.
// No dependencies.
package sisp_pkg;

	localparam int NUM_INPUTS  = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int FIELD_W     = 16;
	localparam int IDX_W       = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int CMP_W       = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	typedef enum logic [1:0] {
		STAGE_LOAD     = 2'd0,
		STAGE_CLK_HIGH = 2'd1,
		STAGE_CLK_LOW  = 2'd2,
		STAGE_SAMPLE   = 2'd3
	} stage_t;

	typedef enum logic [1:0] {
		REG_POLARITY = 2'd0,
		REG_NOISE    = 2'd1,
		REG_STEADY   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [FIELD_W-1:0] polarity_mask;
		logic [FIELD_W-1:0] noise_limit;
		logic [FIELD_W-1:0] steady_limit;
	} cfg_t;

	typedef struct packed {
		logic load_level;
		logic clock_level;
	} pins_t;

	// Inputs beyond the mask have no polarity bit and are active high.
	function automatic logic [NUM_INPUTS-1:0] polarity_vec(input logic [FIELD_W-1:0] mask);
		logic [NUM_INPUTS-1:0] p;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			if (i < FIELD_W) begin
				p[i] = mask[i];
			end else begin
				p[i] = 1'b1;
			end
		end
		return p;
	endfunction

	// Only the first sixteen inputs are shown in the result fields.
	function automatic logic [FIELD_W-1:0] to_field(input logic [NUM_INPUTS-1:0] v);
		logic [FIELD_W-1:0] r;
		for (int i = 0; i < FIELD_W; i++) begin
			if (i < NUM_INPUTS) begin
				r[i] = v[i];
			end else begin
				r[i] = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/sisp_tick_if.sv =====
// Input channel of the scanner: one tick with the serial data pin level.
// Uses no package.
interface sisp_tick_if;
	logic valid;
	logic ready;
	logic serial_level;

	modport source (output valid, output serial_level, input ready);
	modport sink (input valid, input serial_level, output ready);
endinterface

// ===== sv/sisp_result_if.sv =====
// Result channel of the scanner: pin drives and per-input state and flags.
// Depends on sisp_pkg for the field width.
interface sisp_result_if;
	logic                        valid;
	logic                        ready;
	logic                        load_level;
	logic                        clock_level;
	logic [sisp_pkg::FIELD_W-1:0] logic_states;
	logic [sisp_pkg::FIELD_W-1:0] pulse_flags;
	logic [sisp_pkg::FIELD_W-1:0] steady_flags;

	modport source (output valid, output load_level, output clock_level,
		output logic_states, output pulse_flags, output steady_flags, input ready);
	modport sink (input valid, input load_level, input clock_level,
		input logic_states, input pulse_flags, input steady_flags, output ready);
endinterface

// ===== sv/sisp_cfg.sv =====
// APB-style configuration registers: polarity mask, noise and steady limits.
// Depends on sisp_pkg.
module sisp_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sisp_pkg::ADDR_W-1:0] paddr,
	input  logic [sisp_pkg::DATA_W-1:0] pwdata,
	output logic [sisp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output sisp_pkg::cfg_t              cfg
);

	sisp_pkg::cfg_t   cfg_q;
	sisp_pkg::reg_idx_t reg_idx;
	logic             wr_en;

	assign pready  = 1'b1;
	assign reg_idx = sisp_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polarity_mask <= 16'hFFFF;
			cfg_q.noise_limit   <= 16'd5;
			cfg_q.steady_limit  <= 16'd2000;
		end else if (wr_en) begin
			unique case (reg_idx)
				sisp_pkg::REG_POLARITY: cfg_q.polarity_mask <= pwdata[15:0];
				sisp_pkg::REG_NOISE:    cfg_q.noise_limit   <= pwdata[15:0];
				sisp_pkg::REG_STEADY:   cfg_q.steady_limit  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sisp_pkg::REG_POLARITY: prdata = {16'd0, cfg_q.polarity_mask};
			sisp_pkg::REG_NOISE:    prdata = {16'd0, cfg_q.noise_limit};
			sisp_pkg::REG_STEADY:   prdata = {16'd0, cfg_q.steady_limit};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== sv/sisp_seq.sv =====
// Pin sequencer for the shift register cascade and the sampled active levels.
// Depends on sisp_pkg.
module sisp_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            serial_level,
	input  logic [sisp_pkg::NUM_INPUTS-1:0] polarity,
	output sisp_pkg::pins_t                 pins,
	output logic [sisp_pkg::NUM_INPUTS-1:0] active_q,
	output logic [sisp_pkg::NUM_INPUTS-1:0] active_d
);

	localparam int N  = sisp_pkg::NUM_INPUTS;
	localparam int IW = sisp_pkg::IDX_W;

	sisp_pkg::stage_t stage_q, stage_d;
	logic [IW-1:0]    idx_q, idx_d;
	logic             idx_ok;
	logic             idx_last;
	logic             sample;

	assign idx_ok   = {1'b0, idx_q} < (IW + 1)'(N);
	assign idx_last = idx_q == IW'(N - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= sisp_pkg::STAGE_LOAD;
			idx_q    <= '0;
			active_q <= '0;
		end else if (adv) begin
			stage_q  <= stage_d;
			idx_q    <= idx_d;
			active_q <= active_d;
		end
	end

	always_comb begin
		stage_d = stage_q;
		idx_d   = idx_q;
		sample  = 1'b0;
		unique case (stage_q)
			sisp_pkg::STAGE_LOAD: begin
				pins    = '{load_level: 1'b0, clock_level: 1'b1};
				stage_d = sisp_pkg::STAGE_CLK_HIGH;
			end
			sisp_pkg::STAGE_CLK_HIGH: begin
				pins    = '{load_level: 1'b1, clock_level: 1'b1};
				stage_d = sisp_pkg::STAGE_CLK_LOW;
			end
			sisp_pkg::STAGE_CLK_LOW: begin
				pins    = '{load_level: 1'b1, clock_level: 1'b0};
				stage_d = sisp_pkg::STAGE_SAMPLE;
			end
			sisp_pkg::STAGE_SAMPLE: begin
				pins = '{load_level: 1'b1, clock_level: 1'b0};
				if (idx_ok && !idx_last) begin
					sample  = 1'b1;
					idx_d   = idx_q + 1'b1;
					stage_d = sisp_pkg::STAGE_CLK_HIGH;
				end else begin
					sample  = idx_ok;
					idx_d   = '0;
					stage_d = sisp_pkg::STAGE_LOAD;
				end
			end
			default: begin
				pins    = '{load_level: 1'b1, clock_level: 1'b0};
				stage_d = sisp_pkg::STAGE_LOAD;
			end
		endcase
	end

	// The first bit shifted out belongs to the highest input.
	always_comb begin
		active_d = active_q;
		for (int i = 0; i < N; i++) begin
			if (sample && idx_q == IW'(N - 1 - i)) begin
				active_d[i] = polarity[i] ? serial_level : ~serial_level;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_ok)
		else $error("bit index beyond the cascade length");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		adv && stage_q == sisp_pkg::STAGE_SAMPLE && idx_last
		|=> stage_q == sisp_pkg::STAGE_LOAD && idx_q == '0)
		else $error("sequencer did not return to load after the last bit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(stage_q) && $stable(idx_q) && $stable(active_q))
		else $error("sequencer moved without a tick");

endmodule

// ===== sv/sisp_cls.sv =====
// Per-input high and low duration counters with pulse and steady flags.
// Depends on sisp_pkg.
module sisp_cls (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  sisp_pkg::cfg_t                  cfg,
	input  logic [sisp_pkg::NUM_INPUTS-1:0] active,
	output logic [sisp_pkg::NUM_INPUTS-1:0] pulse_d,
	output logic [sisp_pkg::NUM_INPUTS-1:0] steady_d
);

	localparam int N  = sisp_pkg::NUM_INPUTS;
	localparam int CW = sisp_pkg::COUNT_WIDTH;
	localparam int MW = sisp_pkg::CMP_W;

	logic [CW-1:0]  high_q [N];
	logic [CW-1:0]  low_q  [N];
	logic [CW-1:0]  high_d [N];
	logic [CW-1:0]  low_d  [N];
	logic [N-1:0]   pulse_q, steady_q;
	logic [N-1:0]   both_nz;
	logic [MW-1:0]  noise_w, steady_w;

	assign noise_w  = MW'(cfg.noise_limit);
	assign steady_w = MW'(cfg.steady_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				high_q[i] <= '0;
				low_q[i]  <= '0;
			end
			pulse_q  <= '0;
			steady_q <= '0;
		end else if (adv) begin
			for (int i = 0; i < N; i++) begin
				high_q[i] <= high_d[i];
				low_q[i]  <= low_d[i];
			end
			pulse_q  <= pulse_d;
			steady_q <= steady_d;
		end
	end

	// On a low tick the pulse flag takes the old high count before a long
	// low time can clear both flags.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			high_d[i]   = high_q[i];
			low_d[i]    = low_q[i];
			pulse_d[i]  = pulse_q[i];
			steady_d[i] = steady_q[i];
			both_nz[i]  = (high_q[i] != '0) && (low_q[i] != '0);
			if (active[i]) begin
				if (high_q[i] != '1) begin
					high_d[i] = high_q[i] + 1'b1;
				end
				low_d[i] = '0;
				if (MW'(high_d[i]) >= steady_w) begin
					steady_d[i] = 1'b1;
				end
			end else begin
				if (low_q[i] != '1) begin
					low_d[i] = low_q[i] + 1'b1;
				end
				if (MW'(high_q[i]) > noise_w) begin
					pulse_d[i] = 1'b1;
				end
				high_d[i] = '0;
				if (MW'(low_d[i]) > steady_w) begin
					pulse_d[i]  = 1'b0;
					steady_d[i] = 1'b0;
				end
			end
		end
	end

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		both_nz == '0)
		else $error("an input has both a high and a low duration running");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pulse_q) && $stable(steady_q))
		else $error("flags changed without a tick");

endmodule

// ===== sv/serial_input_scanner_pulse_classifier.sv =====
// Top level of the serial input scanner and pulse classifier.
// Depends on sisp_pkg, sisp_tick_if, sisp_result_if, sisp_cfg, sisp_seq and sisp_cls.
//
//   channel    | direction | contents
//   -----------+-----------+---------------------------------------------------
//   tick_in    | in        | serial_level
//   result_out | out       | load_level, clock_level, logic_states, pulse_flags,
//              |           | steady_flags
//   APB        | in/out    | polarity_mask, noise_limit, steady_limit at 0, 4, 8
//
// One tick is taken in every cycle unless the result is stalled; the transfer loads
// the input register, and the result is then registered in the result register.
// All counters and flags update in parallel between those registers.
// Reset clears the sequencer, counters and flags and loads the register defaults.
// A stalled result holds the result register; one further tick waits in the input
// register, and only then is tick_in.ready taken low.
module serial_input_scanner_pulse_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	sisp_tick_if.sink                   tick_in,
	sisp_result_if.source               result_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sisp_pkg::ADDR_W-1:0] paddr,
	input  logic [sisp_pkg::DATA_W-1:0] pwdata,
	output logic [sisp_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int N = sisp_pkg::NUM_INPUTS;

	sisp_pkg::cfg_t  cfg;
	sisp_pkg::pins_t pins;
	logic [N-1:0]    polarity;
	logic [N-1:0]    active_q, active_d;
	logic [N-1:0]    pulse_d, steady_d;

	logic valid_s1;
	logic serial_s1;
	logic out_valid_q;
	logic adv;

	assign adv           = valid_s1 && (!out_valid_q || result_out.ready);
	assign tick_in.ready = !valid_s1 || adv;
	assign polarity      = sisp_pkg::polarity_vec(cfg.polarity_mask);

	sisp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sisp_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.serial_level (serial_s1),
		.polarity     (polarity),
		.pins         (pins),
		.active_q     (active_q),
		.active_d     (active_d)
	);

	sisp_cls u_cls (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg),
		.active   (active_q),
		.pulse_d  (pulse_d),
		.steady_d (steady_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_in.valid && tick_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) begin
			serial_s1 <= tick_in.serial_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_out.load_level   <= pins.load_level;
			result_out.clock_level  <= pins.clock_level;
			result_out.logic_states <= sisp_pkg::to_field(active_d);
			result_out.pulse_flags  <= sisp_pkg::to_field(pulse_d);
			result_out.steady_flags <= sisp_pkg::to_field(steady_d);
		end
	end

	assign result_out.valid = out_valid_q;

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_in.ready |-> valid_s1 && out_valid_q && !result_out.ready)
		else $error("input stalled while the result path could move");

	a_pins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_out.load_level |-> result_out.clock_level)
		else $error("load driven low without the clock held high");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("tick processed but no result registered");

endmodule

// ===== dv/serial_input_scanner_pulse_classifier_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for serial_input_scanner_pulse_classifier.
// Depends on sisp_pkg, sisp_tick_if, sisp_result_if and the block itself; a predictor
// of the pin sequencer and per-input classifier checks every result transfer.
module serial_input_scanner_pulse_classifier_tb;

	localparam int NUM_INPUTS  = sisp_pkg::NUM_INPUTS;
	localparam int COUNT_WIDTH = sisp_pkg::COUNT_WIDTH;
	localparam int FIELD_W     = sisp_pkg::FIELD_W;
	localparam int ADDR_W      = sisp_pkg::ADDR_W;
	localparam int DATA_W      = sisp_pkg::DATA_W;

	localparam int SCAN_LEN = 1 + 3 * NUM_INPUTS;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic               load_level;
		logic               clock_level;
		logic [FIELD_W-1:0] logic_states;
		logic [FIELD_W-1:0] pulse_flags;
		logic [FIELD_W-1:0] steady_flags;
	} scan_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	sisp_tick_if tick_bus ();
	sisp_result_if result_bus ();

	serial_input_scanner_pulse_classifier u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_in    (tick_bus),
		.result_out (result_bus),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Predictor state: a copy of the registers and of the scanner.
	sisp_pkg::cfg_t         shadow_cfg;
	sisp_pkg::stage_t       scan_pos = sisp_pkg::STAGE_LOAD;
	int                     bit_pos = 0;
	logic [NUM_INPUTS-1:0]  lvl_active = '0;
	logic [NUM_INPUTS-1:0]  pulse_set = '0;
	logic [NUM_INPUTS-1:0]  steady_set = '0;
	logic [COUNT_WIDTH-1:0] hi_cnt [NUM_INPUTS] = '{default: '0};
	logic [COUNT_WIDTH-1:0] lo_cnt [NUM_INPUTS] = '{default: '0};

	scan_result_t expected_results [$];
	logic         serial_q [$];
	logic [NUM_INPUTS-1:0] gen_want;
	int unsigned  ticks_queued;
	int unsigned  ticks_accepted = 0;
	int unsigned  results_seen = 0;
	int unsigned  fail_cnt = 0;
	int unsigned  send_gap;
	int unsigned  recv_gap;
	bit           idle_en;
	bit           hold_go;
	logic         rx_hold;
	scan_result_t exp_r;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("ERROR: %s got 0x%0h expected 0x%0h (result %0d)", what, got, want,
			results_seen);
		fail_cnt++;
	endtask

	// One tick: counters and flags move first, from the levels held before the tick,
	// then the pin sequencer steps and may sample one input.
	task automatic advance_scanner(input logic serial);
		scan_result_t r;
		int slot;
		logic pol;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			if (lvl_active[i]) begin
				if (hi_cnt[i] != CNT_MAX) hi_cnt[i]++;
				lo_cnt[i] = '0;
				if (hi_cnt[i] >= shadow_cfg.steady_limit) steady_set[i] = 1'b1;
			end else begin
				if (lo_cnt[i] != CNT_MAX) lo_cnt[i]++;
				// The pulse flag comes from the old high count before any clearing.
				if (hi_cnt[i] > shadow_cfg.noise_limit) pulse_set[i] = 1'b1;
				hi_cnt[i] = '0;
				if (lo_cnt[i] > shadow_cfg.steady_limit) begin
					pulse_set[i] = 1'b0;
					steady_set[i] = 1'b0;
				end
			end
		end
		r = '0;
		case (scan_pos)
			sisp_pkg::STAGE_LOAD: begin
				r.load_level = 1'b0;
				r.clock_level = 1'b1;
				scan_pos = sisp_pkg::STAGE_CLK_HIGH;
			end
			sisp_pkg::STAGE_CLK_HIGH: begin
				r.load_level = 1'b1;
				r.clock_level = 1'b1;
				scan_pos = sisp_pkg::STAGE_CLK_LOW;
			end
			sisp_pkg::STAGE_CLK_LOW: begin
				r.load_level = 1'b1;
				r.clock_level = 1'b0;
				scan_pos = sisp_pkg::STAGE_SAMPLE;
			end
			default: begin
				r.load_level = 1'b1;
				r.clock_level = 1'b0;
				slot = NUM_INPUTS - 1 - bit_pos;
				pol = (slot < FIELD_W) ? shadow_cfg.polarity_mask[slot] : 1'b1;
				lvl_active[slot] = pol ? serial : ~serial;
				bit_pos++;
				if (bit_pos == NUM_INPUTS) begin
					bit_pos = 0;
					scan_pos = sisp_pkg::STAGE_LOAD;
				end else begin
					scan_pos = sisp_pkg::STAGE_CLK_HIGH;
				end
			end
		endcase
		for (int i = 0; i < NUM_INPUTS && i < FIELD_W; i++) begin
			r.logic_states[i] = lvl_active[i];
			r.pulse_flags[i] = pulse_set[i];
			r.steady_flags[i] = steady_set[i];
		end
		expected_results.push_back(r);
	endtask

	// Ticks follow a wanted level per input; the serial level only matters on the
	// sample tick of the input being shifted out, so the other ticks carry noise.
	task automatic queue_ticks(input int count, input int flip_pct, input int noise_pct);
		int pos;
		int tgt;
		logic lvl;
		repeat (count) begin
			pos = ticks_queued % SCAN_LEN;
			lvl = 1'($urandom_range(0, 1));
			if (pos != 0 && pos % 3 == 0) begin
				tgt = NUM_INPUTS - pos / 3;
				if ($urandom_range(0, 99) < flip_pct) gen_want[tgt] = ~gen_want[tgt];
				if ($urandom_range(0, 99) >= noise_pct) lvl = gen_want[tgt];
			end
			serial_q.push_back(lvl);
			ticks_queued++;
		end
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] idx,
		input logic [FIELD_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= DATA_W'(wdata);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [FIELD_W-1:0] val);
		logic [DATA_W-1:0] rd;
		apb_xfer(1'b1, idx, val, rd);
		case (idx)
			sisp_pkg::REG_POLARITY: shadow_cfg.polarity_mask = val;
			sisp_pkg::REG_NOISE:    shadow_cfg.noise_limit = val;
			sisp_pkg::REG_STEADY:   shadow_cfg.steady_limit = val;
			default: ;
		endcase
		if (idx != REG_UNUSED) begin
			apb_xfer(1'b0, idx, '0, rd);
			if (rd[FIELD_W-1:0] !== val) report_mismatch("register readback", rd, 32'(val));
		end
	endtask

	task automatic set_limits(input logic [FIELD_W-1:0] pol, input logic [FIELD_W-1:0] noise,
		input logic [FIELD_W-1:0] steady);
		apb_write(sisp_pkg::REG_POLARITY, pol);
		apb_write(sisp_pkg::REG_NOISE, noise);
		apb_write(sisp_pkg::REG_STEADY, steady);
	endtask

	// Waits until every queued tick has been taken and every result has come back,
	// then lets the two-stage pipeline settle.
	task automatic drain();
		while (ticks_accepted != ticks_queued) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Tick driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
			tick_bus.serial_level <= 1'b0;
			send_gap <= 0;
		end else begin
			if (tick_bus.valid && tick_bus.ready) begin
				advance_scanner(tick_bus.serial_level);
				ticks_accepted++;
			end
			if (!tick_bus.valid || tick_bus.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					tick_bus.valid <= 1'b0;
				end else if (idle_en && $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(0, 9);
					tick_bus.valid <= 1'b0;
				end else if (serial_q.size() != 0) begin
					tick_bus.valid <= 1'b1;
					tick_bus.serial_level <= serial_q.pop_front();
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with nothing pending", 0, 0);
				end else begin
					exp_r = expected_results.pop_front();
					if (result_bus.load_level !== exp_r.load_level)
						report_mismatch("load_level", 32'(result_bus.load_level),
							32'(exp_r.load_level));
					if (result_bus.clock_level !== exp_r.clock_level)
						report_mismatch("clock_level", 32'(result_bus.clock_level),
							32'(exp_r.clock_level));
					if (result_bus.logic_states !== exp_r.logic_states)
						report_mismatch("logic_states", 32'(result_bus.logic_states),
							32'(exp_r.logic_states));
					if (result_bus.pulse_flags !== exp_r.pulse_flags)
						report_mismatch("pulse_flags", 32'(result_bus.pulse_flags),
							32'(exp_r.pulse_flags));
					if (result_bus.steady_flags !== exp_r.steady_flags)
						report_mismatch("steady_flags", 32'(result_bus.steady_flags),
							32'(exp_r.steady_flags));
				end
				results_seen++;
			end
			if (rx_hold) begin
				result_bus.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				result_bus.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(0, 9);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off, so that the block fills up and stops taking ticks.
	initial begin
		rx_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_en = 1'b1;
		hold_go = 1'b0;
		ticks_queued = 0;
		gen_want = '0;
		shadow_cfg.polarity_mask = 16'hFFFF;
		shadow_cfg.noise_limit = 16'd5;
		shadow_cfg.steady_limit = 16'd2000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults: one load stage and the first eight samples, both levels.
		for (int k = 0; k < 25; k++) begin
			serial_q.push_back(1'((k / 3) % 2));
			ticks_queued++;
		end
		drain();

		// Every limit at zero with low-active inputs; a write past the last register
		// must leave the others alone.
		set_limits(16'h0000, 16'h0000, 16'h0000);
		apb_write(REG_UNUSED, 16'hA5A5);
		queue_ticks(150, 30, 10);
		drain();

		set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_ticks(150, 30, 10);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 150)),
				16'($urandom_range(0, 300)));
			queue_ticks((ph == 2) ? 400 : 180, $urandom_range(5, 40), 10);
			if (ph == 2) hold_go = 1'b1;
			drain();
		end

		// Steady levels: even inputs stay active and odd ones idle past the steady
		// limit, then everything drops long enough to clear the flags.
		idle_en = 1'b0;
		set_limits(16'hFFFF, 16'd3, 16'd40);
		for (int i = 0; i < NUM_INPUTS; i++) gen_want[i] = (i % 2 == 0);
		queue_ticks(150, 0, 0);
		drain();
		gen_want = '0;
		queue_ticks(200, 0, 0);
		drain();

		if (fail_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
